>>> src/pwl_pkg.sv
package pwl_pkg;

	localparam int DATA_W          = 32;
	localparam int INDEX_W         = 4;
	localparam int COUNT_W         = 5;
	localparam int MAX_POINTS_DEF  = 16;

	typedef enum logic {
		ACTION_WRITE = 1'b0,
		ACTION_EVAL  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		REGION_INTERP = 2'd0,
		REGION_FIRST  = 2'd1,
		REGION_LAST   = 2'd2,
		REGION_EMPTY  = 2'd3
	} region_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

>>> src/piecewise_linear_table_eval_unit.sv
// Piecewise-linear table evaluator, signed Q16.16 keys and values.
// Input channel (in_valid / in_stall): each request carries action, entry_index, x_in and
// y_in. A write request stores one breakpoint in the key/value memory and gives no result.
// An evaluate request searches the first point_count entries for the first key >= x_in,
// then clamps to a table end or interpolates between the two neighbouring breakpoints.
// Output channel (out_valid / out_stall): y_out and region, one result per evaluate.
// Configuration channel (cfg_valid / cfg_ready): writes point_count; change it only while
// no evaluate is in flight.
// Sequencing, from an accept to the earliest next accept (the result shows in the same
// cycle as that accept): a write does not leave the idle state. An evaluate is
// serialized: the search reads one entry a cycle from the memory, in order from entry 0.
// An empty table goes straight to the result, and so does a clamp case once the search
// ends. Interpolation adds a 32x32 multiply and a 32-step restoring divider (one quotient
// bit a cycle); the divider is the longest step for interpolated results.
// Reset clears the count register, the sequencer and the output valid; the memory is not
// cleared and an entry must be written before an evaluate reads it.
// A finished result waits in the output register while out_stall is high; the block takes
// new requests meanwhile and holds the next result until that register frees up.
module piecewise_linear_table_eval_unit #(
	parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [pwl_pkg::INDEX_W-1:0]   entry_index,
	input  logic [pwl_pkg::DATA_W-1:0]    x_in,
	input  logic [pwl_pkg::DATA_W-1:0]    y_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pwl_pkg::DATA_W-1:0]    y_out,
	output logic [1:0]                    region,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwl_pkg::COUNT_W-1:0]   point_count
);
	import pwl_pkg::*;

	localparam int W        = DATA_W;
	localparam int AW       = $clog2(MAX_POINTS);
	localparam int CW       = $clog2(MAX_POINTS + 1);
	localparam int DCW      = $clog2(W);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(W - 1);

	// key/value memory, one entry per breakpoint, registered read
	logic [2*W-1:0] mem [MAX_POINTS];
	logic [2*W-1:0] rd_data_q;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic           mem_we;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] point_count_q;
	logic               out_valid_q;
	logic [W-1:0]       y_out_q;
	region_t            region_q;

	logic [CW-1:0]      n_q;
	logic [CW-1:0]      n_c;
	logic [AW-1:0]      idx_q;
	logic [W-1:0]       x_q;
	logic [W-1:0]       prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic [W-1:0]       d_q, t_q, mag_q;
	logic               neg_q;
	logic [W-1:0]       rem_q, lo_q;
	logic [DCW-1:0]     div_cnt_q;
	logic [W-1:0]       res_y_q;
	region_t            res_region_q;

	logic               accept, eval_req, slot_ok, out_free, load_out;
	logic               hit, last;
	logic [W-1:0]       rd_key, rd_val;
	logic [AW+INDEX_W-1:0] slot_wide;

	logic [W:0]         dx, dy, tt, dy_mag;
	logic               interp_ok;
	logic [2*W-1:0]     prod;
	logic [W:0]         div_tmp, div_diff;
	logic               div_ge;
	logic [W+1:0]       y1_ext, q_ext, sum;
	logic [W-1:0]       sat_y;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign eval_req  = (action == ACTION_EVAL);
	assign slot_wide = {AW'(0), entry_index};
	assign wr_addr   = slot_wide[AW-1:0];
	assign slot_ok   = 32'(entry_index) < 32'(MAX_POINTS);
	assign out_free  = !out_valid_q || !out_stall;

	// clamp the programmed count to the table depth
	assign n_c = (32'(point_count_q) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
	                                                     : CW'(point_count_q);

	assign rd_key = rd_data_q[2*W-1:W];
	assign rd_val = rd_data_q[W-1:0];
	assign hit    = $signed(rd_key) >= $signed(x_q);
	assign last   = (CW'(idx_q) + CW'(1)) == n_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && eval_req) begin
					state_d = (n_c == '0) ? ST_DONE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = (idx_q == '0) ? ST_DONE : ST_PREP;
				end else if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_PREP: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		mem_we   = 1'b0;
		rd_addr  = '0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				mem_we   = in_valid && !eval_req && slot_ok;
			end
			ST_SEARCH: rd_addr  = idx_q + AW'(1);
			ST_DONE:   load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {x_in, y_in};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				point_count_q <= point_count;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// interpolation operands: x1 < x <= x2 holds by construction of the search
	always_comb begin
		dx        = {cur_x_q[W-1], cur_x_q} - {prev_x_q[W-1], prev_x_q};
		dy        = {cur_y_q[W-1], cur_y_q} - {prev_y_q[W-1], prev_y_q};
		tt        = {x_q[W-1], x_q} - {prev_x_q[W-1], prev_x_q};
		dy_mag    = dy[W] ? (W+1)'(-dy) : dy;
		interp_ok = !dx[W] && (dx != '0) && !tt[W];
	end

	assign prod = (2*W)'(mag_q) * (2*W)'(t_q);

	// one restoring step: bring in the next dividend bit, subtract when it fits
	always_comb begin
		div_tmp  = {rem_q, lo_q[W-1]};
		div_ge   = div_tmp >= {1'b0, d_q};
		div_diff = div_tmp - {1'b0, d_q};
	end

	// y1 +/- quotient, then saturate to 32 bits
	always_comb begin
		y1_ext = {{2{prev_y_q[W-1]}}, prev_y_q};
		q_ext  = {2'b00, lo_q};
		sum    = neg_q ? (y1_ext - q_ext) : (y1_ext + q_ext);
		if ((sum[W+1:W-1] == 3'b000) || (sum[W+1:W-1] == 3'b111)) begin
			sat_y = sum[W-1:0];
		end else if (sum[W+1]) begin
			sat_y = {1'b1, {(W-1){1'b0}}};
		end else begin
			sat_y = {1'b0, {(W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q          <= x_in;
				n_q          <= n_c;
				idx_q        <= '0;
				res_y_q      <= '0;
				res_region_q <= REGION_EMPTY;
			end
			ST_SEARCH: begin
				if (hit) begin
					cur_x_q      <= rd_key;
					cur_y_q      <= rd_val;
					res_y_q      <= rd_val;
					res_region_q <= REGION_FIRST;
				end else begin
					prev_x_q     <= rd_key;
					prev_y_q     <= rd_val;
					res_y_q      <= rd_val;
					res_region_q <= REGION_LAST;
					idx_q        <= idx_q + AW'(1);
				end
			end
			ST_PREP: begin
				// degenerate spans fall back to y1: zero product over a unit divisor
				d_q   <= interp_ok ? dx[W-1:0] : W'(1);
				t_q   <= interp_ok ? tt[W-1:0] : '0;
				mag_q <= interp_ok ? dy_mag[W-1:0] : '0;
				neg_q <= dy[W];
			end
			ST_MUL: begin
				rem_q     <= prod[2*W-1:W];
				lo_q      <= prod[W-1:0];
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q     <= div_ge ? div_diff[W-1:0] : div_tmp[W-1:0];
				lo_q      <= {lo_q[W-2:0], div_ge};
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			ST_FIN: begin
				res_y_q      <= sat_y;
				res_region_q <= REGION_INTERP;
			end
			ST_DONE: begin
				if (load_out) begin
					y_out_q  <= res_y_q;
					region_q <= res_region_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign y_out     = y_out_q;
	assign region    = region_q;

endmodule

>>> src/pwl_chk.sv
module pwl_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          action,
	input logic [pwl_pkg::INDEX_W-1:0]   entry_index,
	input logic [pwl_pkg::DATA_W-1:0]    x_in,
	input logic [pwl_pkg::DATA_W-1:0]    y_in,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pwl_pkg::DATA_W-1:0]    y_out,
	input logic [1:0]                    region,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [pwl_pkg::COUNT_W-1:0]   point_count
);
	import pwl_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(y_out) && $stable(region))
		else $error("stalled result changed");

	// an empty table always reads as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (region != REGION_EMPTY) || (y_out == '0))
		else $error("empty-table result not zero");

	// an accepted evaluate holds the input stalled behind it
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACTION_EVAL) |=> in_stall)
		else $error("evaluate did not hold the input");

	// a breakpoint write does not stall the input
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACTION_WRITE) |=> !in_stall)
		else $error("write stalled the input");

endmodule

bind piecewise_linear_table_eval_unit pwl_chk u_pwl_chk (.*);
